FILE: src/ffsa_pkg.sv
package ffsa_pkg;

	localparam logic [1:0] FUNC_INIT  = 2'd0;
	localparam logic [1:0] FUNC_ALLOC = 2'd1;
	localparam logic [1:0] FUNC_FREE  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_READY = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_NO_FIT    = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	localparam logic [0:0] REG_HEAP_BASE  = 1'd0;
	localparam logic [0:0] REG_HEAP_BYTES = 1'd1;

	localparam logic [31:0] HEAP_RESET_BYTES = 32'h0000_8000;
	localparam logic [31:0] GRAIN_MASK       = 32'hFFFF_FFF8;
	localparam logic [33:0] GRAIN_ROUND      = 34'd7;
	localparam logic [33:0] GRAIN_GUARD      = 34'd8;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] request_size;
		logic [31:0] release_address;
	} ffsa_in_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [31:0] granted_bytes;
		logic [2:0]  status;
	} ffsa_out_t;

endpackage

FILE: src/first_fit_segment_allocator_top.sv
// First-fit segment allocator with coalescing.
//
// Command channel: item is taken when start is high and busy is low.
// item.func selects init (clear tables, load heap_base/heap_bytes as one
// free segment), allocate (request rounded up to 8, plus 8 guard bytes)
// or free (release the used segment starting at release_address).
// Result channel: done pulses for one cycle with result; every command
// gives exactly one result. The receiver cannot stall, so results are
// never held; a new command may start in the cycle done is high.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle; not enforced by the block.
// Command steps:
//   init           clearing sweep of both tables
//   allocate       one joint scan of free and used tables
//   free           used-table lookup, free-table neighbor
//                  scan, then three sequential write states for the free table
//   not-ready, overflow or unknown func: result the cycle after acceptance.
// The one-read-port table memories set the scan pace: one entry a cycle.
// After reset busy stays high while both tables are
// swept to empty; configuration writes are still taken then.
module first_fit_segment_allocator_top #(
	parameter int TABLE_ENTRIES = 128,
	parameter int ADDR_BITS     = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ffsa_pkg::ffsa_in_t  item,
	output logic                done,
	output ffsa_pkg::ffsa_out_t result,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import ffsa_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int DW = ADDR_BITS + 32;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_ASCAN = 4'd2;
	localparam logic [3:0] S_USCAN = 4'd3;
	localparam logic [3:0] S_FSCAN = 4'd4;
	localparam logic [3:0] S_WPRED = 4'd5;
	localparam logic [3:0] S_WSUCC = 4'd6;
	localparam logic [3:0] S_WSLOT = 4'd7;

	function automatic logic [31:0] lo32(input logic [ADDR_BITS-1:0] a);
		logic [ADDR_BITS+31:0] x;
		x = {32'b0, a};
		return x[31:0];
	endfunction

	function automatic logic [ADDR_BITS-1:0] to_addr(input logic [31:0] v);
		logic [ADDR_BITS+31:0] x;
		x = {{ADDR_BITS{1'b0}}, v};
		return x[ADDR_BITS-1:0];
	endfunction

	// configuration
	logic [31:0] heap_base_q, heap_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_bytes_q <= HEAP_RESET_BYTES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAP_BASE:  heap_base_q  <= cfg_data;
				REG_HEAP_BYTES: heap_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// table memories: {start, size}, size zero marks an unused entry
	logic          f_we, u_we;
	logic [IW-1:0] f_wa, u_wa;
	logic [DW-1:0] f_wd, u_wd;
	logic [DW-1:0] f_rd, u_rd;
	logic [IW-1:0] idx_q;

	ffsa_table #(.DEPTH(TABLE_ENTRIES), .AW(IW), .DW(DW)) u_free_tab (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(idx_q), .rdata(f_rd)
	);
	ffsa_table #(.DEPTH(TABLE_ENTRIES), .AW(IW), .DW(DW)) u_used_tab (
		.clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(idx_q), .rdata(u_rd)
	);

	logic [ADDR_BITS-1:0] f_rstart, u_rstart;
	logic [31:0]          f_rsize, u_rsize;
	assign f_rstart = f_rd[DW-1:32];
	assign f_rsize  = f_rd[31:0];
	assign u_rstart = u_rd[DW-1:32];
	assign u_rsize  = u_rd[31:0];

	// control
	logic [3:0]  state_q;
	logic        iss_q, vld_s1;
	logic [IW-1:0] idx_s1;
	logic        init_q, ready_q;
	logic        done_q;
	ffsa_out_t   res_q;

	// per-command working registers
	logic [31:0]          need_q;
	logic [ADDR_BITS-1:0] addr_q;      // release address, then segment start
	logic [31:0]          z_q;         // released segment size
	logic [ADDR_BITS-1:0] e_q;         // released segment end
	logic                 a_found_q, b_found_q, c_found_q;
	logic [IW-1:0]        a_idx_q, b_idx_q, c_idx_q;
	logic [ADDR_BITS-1:0] a_start_q;
	logic [31:0]          a_size_q, b_size_q;
	// alloc: a = used slot, b = fitting free entry (b_start in a_start_q)
	// free:  a = pred, b = succ, c = unused free slot; hit in h_*
	logic                 h_found_q;
	logic [IW-1:0]        h_idx_q;
	logic [ADDR_BITS-1:0] b_start_q;

	logic scan_end;
	assign scan_end = !iss_q && !vld_s1;

	logic [33:0] need_w;
	assign need_w = (({2'b0, item.request_size} + GRAIN_ROUND) & {2'b11, GRAIN_MASK})
		+ GRAIN_GUARD;

	logic [ADDR_BITS-1:0] f_end;
	assign f_end = f_rstart + to_addr(f_rsize);

	logic [31:0] init_bytes;
	assign init_bytes = heap_bytes_q & GRAIN_MASK;

	// free-table slot decision at the end of the neighbor scan
	logic          slot_ok;
	logic [IW-1:0] slot_idx;
	always_comb begin
		slot_ok  = 1'b1;
		slot_idx = c_idx_q;
		if (!c_found_q) begin
			if (a_found_q && (!b_found_q || a_idx_q < b_idx_q)) begin
				slot_idx = a_idx_q;
			end else if (b_found_q) begin
				slot_idx = b_idx_q;
			end else begin
				slot_ok = 1'b0;
			end
		end
	end

	// memory writes
	always_comb begin
		f_we = 1'b0;
		f_wa = idx_q;
		f_wd = '0;
		u_we = 1'b0;
		u_wa = idx_q;
		u_wd = '0;
		case (state_q)
			S_CLR: begin
				f_we = iss_q;
				u_we = iss_q;
				if (init_q && idx_q == '0) begin
					f_wd = {to_addr(heap_base_q), init_bytes};
				end
			end
			S_ASCAN: begin
				if (scan_end && a_found_q && b_found_q) begin
					u_we = 1'b1;
					u_wa = a_idx_q;
					u_wd = {a_start_q, need_q};
					f_we = 1'b1;
					f_wa = b_idx_q;
					if (a_size_q != need_q) begin
						f_wd = {a_start_q + to_addr(need_q), a_size_q - need_q};
					end
				end
			end
			S_WPRED: begin
				f_we = a_found_q;
				f_wa = a_idx_q;
				u_we = 1'b1;
				u_wa = h_idx_q;
			end
			S_WSUCC: begin
				f_we = b_found_q;
				f_wa = b_idx_q;
			end
			S_WSLOT: begin
				f_we = 1'b1;
				f_wa = c_idx_q;
				f_wd = {a_found_q ? b_start_q : addr_q, z_q + a_size_q + b_size_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			iss_q   <= 1'b1;
			vld_s1  <= 1'b0;
			idx_q   <= '0;
			init_q  <= 1'b0;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= iss_q;
			if (iss_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LAST) begin
					iss_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q     <= '0;
						idx_q     <= '0;
						a_found_q <= 1'b0;
						b_found_q <= 1'b0;
						c_found_q <= 1'b0;
						h_found_q <= 1'b0;
						need_q    <= need_w[31:0];
						addr_q    <= to_addr(item.release_address);
						case (item.func)
							FUNC_INIT: begin
								init_q  <= 1'b1;
								iss_q   <= 1'b1;
								state_q <= S_CLR;
							end
							FUNC_ALLOC: begin
								if (!ready_q) begin
									res_q.status <= ST_NOT_READY;
									done_q       <= 1'b1;
								end else if (need_w[33:32] != 2'b0) begin
									res_q.status <= ST_OVERFLOW;
									done_q       <= 1'b1;
								end else begin
									iss_q   <= 1'b1;
									state_q <= S_ASCAN;
								end
							end
							FUNC_FREE: begin
								if (!ready_q) begin
									res_q.status <= ST_NOT_READY;
									done_q       <= 1'b1;
								end else begin
									iss_q   <= 1'b1;
									state_q <= S_USCAN;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_CLR: begin
					if (scan_end) begin
						if (init_q) begin
							ready_q <= 1'b1;
							done_q  <= 1'b1;
						end
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_ASCAN: begin
					if (vld_s1) begin
						if (u_rsize == '0 && !a_found_q) begin
							a_found_q <= 1'b1;
							a_idx_q   <= idx_s1;
						end
						if (f_rsize != '0 && f_rsize >= need_q && !b_found_q) begin
							b_found_q <= 1'b1;
							b_idx_q   <= idx_s1;
							a_start_q <= f_rstart;
							a_size_q  <= f_rsize;
						end
					end
					if (scan_end) begin
						if (!a_found_q) begin
							res_q.status <= ST_FULL;
						end else if (!b_found_q) begin
							res_q.status <= ST_NO_FIT;
						end else begin
							res_q.granted_address <= lo32(a_start_q);
							res_q.granted_bytes   <= need_q;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_USCAN: begin
					if (vld_s1 && u_rsize != '0 && u_rstart == addr_q && !h_found_q) begin
						h_found_q <= 1'b1;
						h_idx_q   <= idx_s1;
						z_q       <= u_rsize;
						e_q       <= u_rstart + to_addr(u_rsize);
					end
					if (scan_end) begin
						if (!h_found_q) begin
							res_q.status <= ST_NOT_FOUND;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							a_size_q <= '0;
							b_size_q <= '0;
							idx_q    <= '0;
							iss_q    <= 1'b1;
							state_q  <= S_FSCAN;
						end
					end
				end
				S_FSCAN: begin
					if (vld_s1) begin
						if (f_rsize == '0) begin
							if (!c_found_q) begin
								c_found_q <= 1'b1;
								c_idx_q   <= idx_s1;
							end
						end else if (!a_found_q && f_end == addr_q) begin
							a_found_q <= 1'b1;
							a_idx_q   <= idx_s1;
							b_start_q <= f_rstart;
							a_size_q  <= f_rsize;
						end else if (!b_found_q && f_rstart == e_q) begin
							b_found_q <= 1'b1;
							b_idx_q   <= idx_s1;
							b_size_q  <= f_rsize;
						end
					end
					if (scan_end) begin
						if (!slot_ok) begin
							res_q.status <= ST_FULL;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							c_idx_q <= slot_idx;
							state_q <= S_WPRED;
						end
					end
				end
				S_WPRED: state_q <= S_WSUCC;
				S_WSUCC: state_q <= S_WSLOT;
				S_WSLOT: begin
					res_q.granted_bytes <= z_q;
					done_q              <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: src/ffsa_table.sv
module ffsa_table #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
